// ===== hdl/scancode_to_ascii_decoder_defines.svh =====
// Assertion macros for the scan code decoder checker.
// No dependencies; included by the checker file.
`ifndef SCANCODE_TO_ASCII_DECODER_DEFINES_SVH
`define SCANCODE_TO_ASCII_DECODER_DEFINES_SVH

// Checked on every clk edge outside reset.
`define S2A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clk edge, reset included.
`define S2A_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/s2a_pkg.sv =====
// Shared types, constants and key tables for the scan code decoder.
// No dependencies.
package s2a_pkg;

  localparam logic [7:0] RELEASE_BIT   = 8'h80;
  localparam logic [7:0] LSHIFT_MAKE   = 8'h2A;
  localparam logic [7:0] RSHIFT_MAKE   = 8'h36;
  localparam logic [7:0] CAPS_MAKE     = 8'h3A;
  localparam logic [7:0] LSHIFT_BREAK  = 8'hAA;
  localparam logic [7:0] RSHIFT_BREAK  = 8'hB6;
  localparam logic [3:0] REPORT_LAST   = 4'd13;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef struct packed {
    logic       is_report;
    logic [7:0] data;
  } entry_t;

  function automatic logic [7:0] plain_char(input logic [6:0] c);
    logic [7:0] r;
    case (c)
      7'h02: r = "1";  7'h03: r = "2";  7'h04: r = "3";  7'h05: r = "4";
      7'h06: r = "5";  7'h07: r = "6";  7'h08: r = "7";  7'h09: r = "8";
      7'h0A: r = "9";  7'h0B: r = "0";
      7'h10: r = "q";  7'h11: r = "w";  7'h12: r = "e";  7'h13: r = "r";
      7'h14: r = "t";  7'h15: r = "z";  7'h16: r = "u";  7'h17: r = "i";
      7'h18: r = "o";  7'h19: r = "p";
      7'h1E: r = "a";  7'h1F: r = "s";  7'h20: r = "d";  7'h21: r = "f";
      7'h22: r = "g";  7'h23: r = "h";  7'h24: r = "j";  7'h25: r = "k";
      7'h26: r = "l";
      7'h2C: r = "y";  7'h2D: r = "x";  7'h2E: r = "c";  7'h2F: r = "v";
      7'h30: r = "b";  7'h31: r = "n";  7'h32: r = "m";  7'h33: r = ",";
      7'h34: r = ".";  7'h35: r = "-";
      7'h1C: r = 8'h0A;
      7'h39: r = " ";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] shifted_char(input logic [6:0] c);
    logic [7:0] r;
    case (c)
      7'h02: r = "!";  7'h03: r = "@";  7'h04: r = "#";  7'h05: r = "$";
      7'h06: r = "%";  7'h07: r = "^";  7'h08: r = "&";  7'h09: r = "*";
      7'h0A: r = "(";  7'h0B: r = ")";
      7'h33: r = "<";  7'h34: r = ">";  7'h35: r = "_";
      7'h1C: r = 8'h0A;
      7'h39: r = " ";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

  // "KEYBOARD 0xHH "
  function automatic logic [7:0] report_char(input logic [3:0] idx, input logic [7:0] code);
    logic [7:0] r;
    case (idx)
      4'd0:  r = "K";
      4'd1:  r = "E";
      4'd2:  r = "Y";
      4'd3:  r = "B";
      4'd4:  r = "O";
      4'd5:  r = "A";
      4'd6:  r = "R";
      4'd7:  r = "D";
      4'd8:  r = " ";
      4'd9:  r = "0";
      4'd10: r = "x";
      4'd11: r = hex_char(code[7:4]);
      4'd12: r = hex_char(code[3:0]);
      4'd13: r = " ";
      default: r = " ";
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/s2a_front.sv =====
// Front end: takes scan codes, tracks shift and caps lock, classifies keys.
// Depends on s2a_pkg.
module s2a_front
  import s2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_code,
  output logic       push_valid,
  input  logic       push_ready,
  output entry_t     push_entry
);

  logic       shift_r, shift_nxt;
  logic       caps_r, caps_nxt;
  logic       accept;
  logic       is_break, is_shift_make, is_caps_make;
  logic [7:0] base, shifted;
  logic       is_letter;

  assign in_ready      = push_ready;
  assign accept        = in_valid && in_ready;
  assign is_break      = (in_scan_code & RELEASE_BIT) != 8'h00;
  assign is_shift_make = (in_scan_code == LSHIFT_MAKE) || (in_scan_code == RSHIFT_MAKE);
  assign is_caps_make  = in_scan_code == CAPS_MAKE;
  assign base          = plain_char(in_scan_code[6:0]);
  assign shifted       = shifted_char(in_scan_code[6:0]);
  assign is_letter     = (base >= "a") && (base <= "z");

  always_comb begin
    shift_nxt            = shift_r;
    caps_nxt             = caps_r;
    push_valid           = 1'b0;
    push_entry.is_report = 1'b0;
    push_entry.data      = base;
    if (is_break) begin
      if ((in_scan_code == LSHIFT_BREAK) || (in_scan_code == RSHIFT_BREAK)) begin
        shift_nxt = 1'b0;
      end
    end else if (is_shift_make) begin
      shift_nxt = 1'b1;
    end else if (is_caps_make) begin
      caps_nxt = !caps_r;
    end else if (base == 8'h00) begin
      push_valid           = in_valid;
      push_entry.is_report = 1'b1;
      push_entry.data      = in_scan_code;
    end else begin
      push_valid = in_valid;
      if (is_letter) begin
        if (shift_r != caps_r) begin
          push_entry.data = base - CASE_OFFSET;
        end
      end else if (shift_r) begin
        push_entry.data = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

endmodule

// ===== hdl/s2a_queue.sv =====
// Small FIFO between the front end and the output sequencer.
// Depends on s2a_pkg.
module s2a_queue
  import s2a_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != FULL_CNT;
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/s2a_back.sv =====
// Output sequencer: emits single characters and streams the unknown-key report.
// Depends on s2a_pkg.
module s2a_back
  import s2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  entry_t     pop_entry,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_character,
  output logic       out_last_of_run
);

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       run_r;
  logic [3:0] run_idx_r;
  logic [7:0] run_code_r;
  logic       load;

  assign load            = !out_valid_r || out_ready;
  assign pop_ready       = load && !run_r;
  assign out_valid       = out_valid_r;
  assign out_character   = out_char_r;
  assign out_last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_r       <= 1'b0;
      run_idx_r   <= '0;
    end else if (load) begin
      if (run_r) begin
        out_valid_r <= 1'b1;
        out_char_r  <= report_char(run_idx_r, run_code_r);
        out_last_r  <= run_idx_r == REPORT_LAST;
        run_idx_r   <= run_idx_r + 1'b1;
        run_r       <= run_idx_r != REPORT_LAST;
      end else if (pop_valid) begin
        out_valid_r <= 1'b1;
        if (pop_entry.is_report) begin
          out_char_r <= report_char(4'd0, pop_entry.data);
          out_last_r <= 1'b0;
          run_r      <= 1'b1;
          run_idx_r  <= 4'd1;
          run_code_r <= pop_entry.data;
        end else begin
          out_char_r <= pop_entry.data;
          out_last_r <= 1'b1;
        end
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/scancode_to_ascii_decoder.sv =====
// Scan code set 1 to ASCII decoder, top level.
// Depends on s2a_pkg, s2a_front, s2a_queue, s2a_back.
//
// A scan code is accepted in the cycle it is offered while the internal queue
// (QUEUE_DEPTH entries, at least 2) has room; shift, caps lock and ignored
// break codes produce no beat. A known key gives one beat, an unknown make
// code gives 14 beats ("KEYBOARD 0xHH "), streamed one per cycle by the output
// sequencer while out_ready is high. Input and output stall independently
// through the queue.
module scancode_to_ascii_decoder
  import s2a_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_character,
  output logic       out_last_of_run
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  s2a_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_code (in_scan_code),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  s2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  s2a_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_entry       (pop_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_character   (out_character),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== hdl/s2a_checker.sv =====
// Port-level checks for the scan code decoder, bound to the top level.
// Depends on scancode_to_ascii_decoder_defines.svh.
`include "scancode_to_ascii_decoder_defines.svh"

module s2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_scan_code,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last_of_run
);

  `S2A_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "out_valid after reset")
  `S2A_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_scan_code), "stalled input changed")
  `S2A_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last_of_run), "stalled beat changed")
  `S2A_ASSERT(a_run_streams, out_valid && out_ready && !out_last_of_run |=> out_valid, "report run gapped")
  `S2A_ASSERT(a_newline_single, out_valid && out_character == 8'h0A |-> out_last_of_run, "newline inside run")

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_scan_code    (in_scan_code),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_character   (out_character),
  .out_last_of_run (out_last_of_run)
);

// ===== verif/scancode_to_ascii_decoder_checker.sv =====
// Scoreboard for the scan code decoder: predicts the ASCII beats of every
// accepted scan code and compares them with the output channel.
// Depends on s2a_pkg for the shift, caps and release codes.
module scancode_to_ascii_decoder_checker
  import s2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_scan_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_character,
  input  logic       out_last_of_run,
  output int         error_count,
  output int         pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_beat_t;

  ascii_beat_t expected_beats[$];
  logic        shift_down;
  logic        caps_lock_on;
  int          beat_index;

  initial begin
    error_count   = 0;
    pending_beats = 0;
    beat_index    = 0;
  end

  // unshifted/shifted glyph per make code, zero for a key without a glyph
  function automatic logic [7:0] key_glyph(input logic [6:0] c, input logic shifted);
    logic [7:0] g;
    case (c)
      7'h02: g = shifted ? "!" : "1";
      7'h03: g = shifted ? "@" : "2";
      7'h04: g = shifted ? "#" : "3";
      7'h05: g = shifted ? "$" : "4";
      7'h06: g = shifted ? "%" : "5";
      7'h07: g = shifted ? "^" : "6";
      7'h08: g = shifted ? "&" : "7";
      7'h09: g = shifted ? "*" : "8";
      7'h0A: g = shifted ? "(" : "9";
      7'h0B: g = shifted ? ")" : "0";
      7'h33: g = shifted ? "<" : ",";
      7'h34: g = shifted ? ">" : ".";
      7'h35: g = shifted ? "_" : "-";
      7'h1C: g = 8'h0A;
      7'h39: g = " ";
      7'h10: g = "q";  7'h11: g = "w";  7'h12: g = "e";  7'h13: g = "r";
      7'h14: g = "t";  7'h15: g = "z";  7'h16: g = "u";  7'h17: g = "i";
      7'h18: g = "o";  7'h19: g = "p";
      7'h1E: g = "a";  7'h1F: g = "s";  7'h20: g = "d";  7'h21: g = "f";
      7'h22: g = "g";  7'h23: g = "h";  7'h24: g = "j";  7'h25: g = "k";
      7'h26: g = "l";
      7'h2C: g = "y";  7'h2D: g = "x";  7'h2E: g = "c";  7'h2F: g = "v";
      7'h30: g = "b";  7'h31: g = "n";  7'h32: g = "m";
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] n);
    return (n < 4'd10) ? (8'd48 + 8'(n)) : (8'd55 + 8'(n));
  endfunction

  task automatic push_beat(input logic [7:0] ch, input logic last);
    ascii_beat_t b;
    b.ch   = ch;
    b.last = last;
    expected_beats.push_back(b);
  endtask

  task automatic predict_scan_code(input logic [7:0] code);
    logic [7:0] ch;
    string      prefix;
    prefix = "KEYBOARD 0x";
    if (code[7]) begin
      if (code == LSHIFT_BREAK || code == RSHIFT_BREAK) shift_down = 1'b0;
    end else if (code == LSHIFT_MAKE || code == RSHIFT_MAKE) begin
      shift_down = 1'b1;
    end else if (code == CAPS_MAKE) begin
      caps_lock_on = !caps_lock_on;
    end else begin
      ch = key_glyph(code[6:0], shift_down);
      if (ch == 8'h00) begin
        for (int i = 0; i < prefix.len(); i++) push_beat(prefix[i], 1'b0);
        push_beat(hex_glyph(code[7:4]), 1'b0);
        push_beat(hex_glyph(code[3:0]), 1'b0);
        push_beat(" ", 1'b1);
      end else begin
        if (ch >= "a" && ch <= "z" && (shift_down ^ caps_lock_on)) ch = ch - CASE_OFFSET;
        push_beat(ch, 1'b1);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH beat %0d: %s", $realtime, beat_index, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    ascii_beat_t exp_beat;
    if (!rst_n) begin
      expected_beats.delete();
      shift_down   = 1'b0;
      caps_lock_on = 1'b0;
    end else begin
      if (in_valid && in_ready) predict_scan_code(in_scan_code);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=%h last=%b",
                                    out_character, out_last_of_run));
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_character !== exp_beat.ch)
            report_mismatch($sformatf("character %h, expected %h",
                                      out_character, exp_beat.ch));
          if (out_last_of_run !== exp_beat.last)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      out_last_of_run, exp_beat.last));
        end
        beat_index++;
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

// ===== verif/tb_scancode_to_ascii_decoder.sv =====
// Top of the scan code decoder testbench: clock, reset, scan code stimulus and
// output stalls; the verdict comes from scancode_to_ascii_decoder_checker.
// Depends on s2a_pkg and the decoder RTL.
module tb_scancode_to_ascii_decoder
  import s2a_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CODES = 235;

  localparam logic [7:0] KNOWN_KEYS [41] = '{
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
    8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
    8'h1C, 8'h39
  };

  localparam logic [7:0] DIRECTED_CODES [25] = '{
    8'h00, 8'h7F, 8'hFF, 8'h80, 8'h10, 8'h1E, 8'h02, 8'h33, 8'h1C, 8'h39,
    LSHIFT_MAKE, 8'h02, 8'h33, 8'h35, 8'h15, LSHIFT_BREAK,
    CAPS_MAKE, 8'h1E, 8'h02, RSHIFT_MAKE, 8'h1E, RSHIFT_BREAK,
    CAPS_MAKE, 8'h81, 8'h01
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_code = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_character;
  logic       out_last_of_run;
  logic       full_rate = 1'b0;
  int         error_count;
  int         pending_beats;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         ready_left = 0;

  always #5 clk = ~clk;

  scancode_to_ascii_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_scan_code    (in_scan_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_character   (out_character),
    .out_last_of_run (out_last_of_run)
  );

  scancode_to_ascii_decoder_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_scan_code    (in_scan_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_character   (out_character),
    .out_last_of_run (out_last_of_run),
    .error_count     (error_count),
    .pending_beats   (pending_beats)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: always ready in full-rate mode, else stall runs, ready runs and cycle-by-cycle coin flips
  always @(posedge clk) begin
    if (full_rate) begin
      out_ready <= 1'b1;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready  <= 1'b0;
          ready_left <= $urandom_range(0, 7);
        end
        1: begin
          out_ready  <= 1'b1;
          ready_left <= $urandom_range(0, 15);
        end
        default: begin
          out_ready  <= 1'($urandom_range(0, 1));
          ready_left <= 0;
        end
      endcase
    end
  end

  task automatic issue_code(input logic [7:0] code);
    if (!full_rate && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end else if (burst_left != 0) begin
      burst_left--;
    end
    in_valid     <= 1'b1;
    in_scan_code <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [7:0] pick_scan_code();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return KNOWN_KEYS[$urandom_range(0, 40)];
    if (roll < 58) return $urandom_range(0, 1) ? LSHIFT_MAKE : RSHIFT_MAKE;
    if (roll < 66) return $urandom_range(0, 1) ? LSHIFT_BREAK : RSHIFT_BREAK;
    if (roll < 70) return CAPS_MAKE;
    if (roll < 80) return KNOWN_KEYS[$urandom_range(0, 40)] | RELEASE_BIT;
    if (roll < 90) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] code;
    int         counted;
    counted = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_CODES[i]) issue_code(DIRECTED_CODES[i]);

    while (counted < RANDOM_CODES) begin
      full_rate <= (counted >= 120 && counted < 160);
      code = pick_scan_code();
      issue_code(code);
      counted++;
    end

    in_valid  <= 1'b0;
    full_rate <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
